// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/pn2d_pkg.sv -----
// Shared types and constants for the 2D gradient noise evaluator
package pn2d_pkg;
	localparam int COORD_W = 24;
	localparam int WORK_BITS = 16;
	localparam int OUT_W = 16;
	localparam int PERM_W = 8;
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W = $clog2(TABLE_SIZE);

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_EVAL = 1'b1
	} kind_t;

	// Signed Q16 values: dot products, lerp operands
	typedef logic signed [19:0] work_t;
	// Fade weight, 0..1.0 in Q16
	typedef logic [16:0] weight_t;

	// Corner gradient dot product from the two low hash bits
	function automatic work_t grad_dot(input logic [1:0] h, input work_t dx, input work_t dy);
		work_t r;
		case (h)
			2'd0: r = dx + dy;
			2'd1: r = dy - dx;
			2'd2: r = -dx - dy;
			default: r = dx - dy;
		endcase
		return r;
	endfunction
endpackage

// ----- rtl/core/perlin_noise_2d_eval.sv -----
// 2D gradient noise evaluator, pipelined, one point per cycle while m_axis does not stall
// Usage:
//  s_axis carries items. tuser = kind (0 load table entry, 1 evaluate point).
//  tdata from the lowest bit: coord_x[23:0], coord_y[23:0], load_index[7:0],
//  load_value[7:0]. A load writes one permutation entry and gives no result;
//  an evaluate gives one result on m_axis: tdata[15:0] = noise_value, Q0.16.
//  Throughput: one item per cycle while m_axis does not stall. An evaluation
//  passes nine register stages, the first loaded by the transfer and the last
//  driving m_axis tvalid, set by the two dependent table reads (column hash,
//  then four corner hashes) and the fade/lerp multiply chain, one multiply per
//  stage. The permutation table is kept in three flop copies, two reads each;
//  a load writes them at the next pipeline advance, in order with evaluations.
//  Evaluations must only touch entries that were loaded.
//  When m_axis stalls the whole pipeline holds; s_axis tready drops only when
//  the final stage is full and not taken. Reset (arst_n low) empties the
//  pipeline; table contents are not cleared.
`include "assert_macros.svh"

module perlin_noise_2d_eval #(
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // coord_x, coord_y, load_index, load_value
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // noise_value
);
	import pn2d_pkg::*;

	localparam int NST = 9;

	// column hash copy, low-column corner copy, high-column corner copy
	logic [PERM_W-1:0] perm_col_q [TABLE_SIZE];
	logic [PERM_W-1:0] perm_lo_q [TABLE_SIZE];
	logic [PERM_W-1:0] perm_hi_q [TABLE_SIZE];

	logic adv;
	logic [NST:1] vld;
	assign adv = !vld[NST] || m_axis_tready;
	assign s_axis_tready = adv;

	logic in_fire;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	logic [COORD_W-1:0] cx_in, cy_in;
	logic [PERM_W-1:0] li_in, lv_in;
	assign cx_in = s_axis_tdata[23:0];
	assign cy_in = s_axis_tdata[47:24];
	assign li_in = s_axis_tdata[55:48];
	assign lv_in = s_axis_tdata[63:56];

	// load travels one stage so it lands between the column and corner reads
	logic ld_s1;
	logic [IDX_W-1:0] li_s1;
	logic [PERM_W-1:0] lv_s1;

	always_ff @(posedge clk) begin
		if (adv && ld_s1) begin
			perm_col_q[li_s1] <= lv_s1;
			perm_lo_q[li_s1] <= lv_s1;
			perm_hi_q[li_s1] <= lv_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
			ld_s1 <= 1'b0;
		end else if (adv) begin
			vld <= {vld[NST-1:1], in_fire && s_axis_tuser == KIND_EVAL};
			ld_s1 <= in_fire && s_axis_tuser == KIND_LOAD;
		end
	end

	// stage 1: split coords
	logic [IDX_W-1:0] cx_s1, cy_s1;
	logic [16:0] tx_s1, ty_s1;
	// stage 2: column hashes
	logic [IDX_W-1:0] cy_s2;
	logic [PERM_W-1:0] px_s2, px1_s2;
	logic [16:0] tx_s2, ty_s2;
	// stage 3: corner hashes; fade q*t
	logic [1:0] hbl_s3, htl_s3, hbr_s3, htr_s3;
	logic [16:0] tx_s3, ty_s3;
	logic signed [39:0] ux_s3, uy_s3;
	// stage 4..6: fade cubes, dots
	work_t bl_s4, tl_s4, br_s4, tr_s4;
	logic [16:0] tx_s4, ty_s4;
	logic signed [39:0] ux_s4, uy_s4;
	work_t bl_s5, tl_s5, br_s5, tr_s5;
	logic [16:0] tx_s5, ty_s5;
	logic signed [39:0] ux_s5, uy_s5;
	work_t bl_s6, tl_s6, br_s6, tr_s6;
	logic signed [39:0] ux_s6, uy_s6;
	// stage 7: first lerps
	work_t l0_s7, l1_s7;
	logic signed [39:0] ux_s7;
	// stage 8: final lerp product; stage 9 out
	logic signed [39:0] p_s8;
	work_t l0_s8;
	logic [OUT_W-1:0] res_s9;

	function automatic logic signed [39:0] fshr(input logic signed [39:0] v);
		return v >>> WORK_BITS;
	endfunction

	// operands fit 21 x 20 signed bits
	function automatic logic signed [39:0] smul(input logic signed [20:0] a,
		input logic signed [19:0] b);
		return 40'(a) * 40'(b);
	endfunction

	function automatic logic signed [39:0] fade_step(input logic signed [39:0] r,
		input logic [16:0] t);
		logic signed [39:0] p;
		p = smul(21'(r), $signed({3'd0, t}));
		return fshr(p);
	endfunction

	logic [IDX_W-1:0] ccx, ccy;
	logic [COORD_W-FRAC_BITS-1:0] wx, wy;
	assign wx = cx_in[COORD_W-1:FRAC_BITS];
	assign wy = cy_in[COORD_W-1:FRAC_BITS];
	assign ccx = IDX_W'(wx);
	assign ccy = IDX_W'(wy);

	logic signed [39:0] qx, qy, qtx, qty;
	assign qx = 40'sd15 * 40'sd65536 - 40'sd6 * $signed({23'd0, tx_s2});
	assign qy = 40'sd15 * 40'sd65536 - 40'sd6 * $signed({23'd0, ty_s2});
	assign qtx = smul(21'(qx), $signed({3'd0, tx_s2}));
	assign qty = smul(21'(qy), $signed({3'd0, ty_s2}));

	work_t dxa, dxb, dya, dyb;
	assign dxa = work_t'({1'b0, tx_s3});
	assign dxb = work_t'({1'b0, tx_s3}) - work_t'(20'sd65536);
	assign dya = work_t'({1'b0, ty_s3});
	assign dyb = work_t'({1'b0, ty_s3}) - work_t'(20'sd65536);

	logic signed [39:0] dl0, dl1, lp0, lp1, wfin;
	assign dl0 = 40'(tl_s6) - 40'(bl_s6);
	assign dl1 = 40'(tr_s6) - 40'(br_s6);
	assign lp0 = fshr(smul(21'(uy_s6), 20'(dl0)));
	assign lp1 = fshr(smul(21'(uy_s6), 20'(dl1)));
	assign wfin = 40'(l0_s8) + fshr(p_s8) + 40'sd65536;

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1 <= ccx;
			cy_s1 <= ccy;
			tx_s1 <= 17'(cx_in[FRAC_BITS-1:0]) << (WORK_BITS - FRAC_BITS);
			ty_s1 <= 17'(cy_in[FRAC_BITS-1:0]) << (WORK_BITS - FRAC_BITS);
			li_s1 <= li_in[IDX_W-1:0];
			lv_s1 <= lv_in;

			cy_s2 <= cy_s1;
			px_s2 <= perm_col_q[cx_s1];
			px1_s2 <= perm_col_q[cx_s1 + IDX_W'(1)];
			tx_s2 <= tx_s1;
			ty_s2 <= ty_s1;

			hbl_s3 <= perm_lo_q[IDX_W'(px_s2) + cy_s2][1:0];
			htl_s3 <= perm_lo_q[IDX_W'(px_s2) + cy_s2 + IDX_W'(1)][1:0];
			hbr_s3 <= perm_hi_q[IDX_W'(px1_s2) + cy_s2][1:0];
			htr_s3 <= perm_hi_q[IDX_W'(px1_s2) + cy_s2 + IDX_W'(1)][1:0];
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;
			ux_s3 <= 40'sd655360 - ((qtx + 40'sd65535) >>> WORK_BITS);
			uy_s3 <= 40'sd655360 - ((qty + 40'sd65535) >>> WORK_BITS);

			bl_s4 <= grad_dot(hbl_s3, dxa, dya);
			tl_s4 <= grad_dot(htl_s3, dxa, dyb);
			br_s4 <= grad_dot(hbr_s3, dxb, dya);
			tr_s4 <= grad_dot(htr_s3, dxb, dyb);
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;
			ux_s4 <= fade_step(ux_s3, tx_s3);
			uy_s4 <= fade_step(uy_s3, ty_s3);

			{bl_s5, tl_s5, br_s5, tr_s5} <= {bl_s4, tl_s4, br_s4, tr_s4};
			tx_s5 <= tx_s4;
			ty_s5 <= ty_s4;
			ux_s5 <= fade_step(ux_s4, tx_s4);
			uy_s5 <= fade_step(uy_s4, ty_s4);

			{bl_s6, tl_s6, br_s6, tr_s6} <= {bl_s5, tl_s5, br_s5, tr_s5};
			ux_s6 <= fade_step(ux_s5, tx_s5);
			uy_s6 <= fade_step(uy_s5, ty_s5);

			l0_s7 <= work_t'(40'(bl_s6) + lp0);
			l1_s7 <= work_t'(40'(br_s6) + lp1);
			ux_s7 <= ux_s6;

			p_s8 <= smul(21'(ux_s7), 20'(40'(l1_s7) - 40'(l0_s7)));
			l0_s8 <= l0_s7;

			// (s+1)/2, clamped
			if (wfin < 0)
				res_s9 <= '0;
			else if (wfin >= 40'sd131072)
				res_s9 <= '1;
			else
				res_s9 <= OUT_W'(wfin >>> 1);
		end
	end

	assign m_axis_tvalid = vld[NST];
	assign m_axis_tdata = res_s9;

	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`ASSERT_NEXT(a_load_no_result, clk, arst_n, in_fire && s_axis_tuser == KIND_LOAD, !vld[1])
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule
